@@ hdl/hpt_pkg.sv @@
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared widths, register indexes and status codes of the homography point
// transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  localparam int COORD_W  = 32;
  localparam int COEF_W   = 32;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 66;
  localparam int STEPS    = 32;
  localparam int LOW_W    = 10;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int ST_W     = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERSPECTIVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd4;

  localparam logic [CFG_W-1:0]  RST_ROW_ONE = 64'h0000_0000_0100_0000;
  localparam logic [CFG_W-1:0]  RST_ROW_TWO = 64'h0100_0000_0000_0000;
  localparam logic [COEF_W-1:0] RST_SCALE   = 32'h0100_0000;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

@@ hdl/homography_point_transform_unit.sv @@
// ----------------------------------------------------------------------------
// homography_point_transform_unit
// Maps Q16.16 points through a configured 3x3 projective matrix.
// ----------------------------------------------------------------------------
// One point enters per clock while the pipeline does not stall. Stage 0
// forms the six 32x32 products, stage 1 the sums u, v, w, stage 2 magnitudes,
// stage 3 the overflow test, then 32 restoring-division stages (u/w and v/w
// side by side, one quotient bit each) and a saturation/output register.
// Each stage stalls only when it holds data and the next one cannot take it.
// Write the matrix registers only while the pipeline is empty.
`default_nettype none

module homography_point_transform_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [hpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hpt_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // x_in [31:0], y_in [63:32]
  input  wire logic [hpt_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // x_out [31:0], y_out [63:32], status [65:64], zero [71:66]
  output logic [hpt_pkg::OUT_DATA_W-1:0]        out_tdata
);

  localparam int LAST = hpt_pkg::STEPS + 4;
  localparam int AW = hpt_pkg::ACC_W;
  localparam int SW = hpt_pkg::STEPS;
  localparam int LW = hpt_pkg::LOW_W;
  localparam int PW = hpt_pkg::PROD_W;

  logic [hpt_pkg::CFG_W-1:0]  row1_r, row2_r, trans_r, persp_r;
  logic [hpt_pkg::COEF_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row1_r  <= hpt_pkg::RST_ROW_ONE;
      row2_r  <= hpt_pkg::RST_ROW_TWO;
      trans_r <= '0;
      persp_r <= '0;
      scale_r <= hpt_pkg::RST_SCALE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hpt_pkg::REG_ROW_ONE:     row1_r  <= cfg_wdata;
        hpt_pkg::REG_ROW_TWO:     row2_r  <= cfg_wdata;
        hpt_pkg::REG_TRANSLATION: trans_r <= cfg_wdata;
        hpt_pkg::REG_PERSPECTIVE: persp_r <= cfg_wdata;
        hpt_pkg::REG_SCALE:       scale_r <= cfg_wdata[hpt_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [0:LAST] vld_r;
  logic [0:LAST] rdy;

  always_comb begin
    rdy[LAST] = !vld_r[LAST] || out_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 0: products
  logic signed [31:0] x_in, y_in;
  logic signed [PW-1:0] p0_r, p1_r, p3_r, p4_r, p6_r, p7_r;

  assign x_in = in_tdata[31:0];
  assign y_in = in_tdata[63:32];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p0_r <= $signed(row1_r[31:0])   * x_in;
      p1_r <= $signed(row1_r[63:32])  * y_in;
      p3_r <= $signed(row2_r[31:0])   * x_in;
      p4_r <= $signed(row2_r[63:32])  * y_in;
      p6_r <= $signed(persp_r[31:0])  * x_in;
      p7_r <= $signed(persp_r[63:32]) * y_in;
    end
  end

  // stage 1: sums
  logic [AW-1:0] u_r, v_r, w_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      u_r <= {{2{p0_r[63]}}, p0_r} + {{2{p1_r[63]}}, p1_r}
           + {{10{trans_r[31]}}, trans_r[31:0], 24'b0};
      v_r <= {{2{p3_r[63]}}, p3_r} + {{2{p4_r[63]}}, p4_r}
           + {{10{trans_r[63]}}, trans_r[63:32], 24'b0};
      w_r <= {{2{p6_r[63]}}, p6_r} + {{2{p7_r[63]}}, p7_r}
           + {{12{scale_r[31]}}, scale_r, 22'b0};
    end
  end

  // stage 2: magnitudes and signs
  logic [AW-1:0] au_r, av_r, aw_r;
  logic          sgx_r, sgy_r, wz_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      au_r  <= u_r[AW-1] ? (~u_r + 1'b1) : u_r;
      av_r  <= v_r[AW-1] ? (~v_r + 1'b1) : v_r;
      aw_r  <= w_r[AW-1] ? (~w_r + 1'b1) : w_r;
      sgx_r <= u_r[AW-1] ^ w_r[AW-1];
      sgy_r <= v_r[AW-1] ^ w_r[AW-1];
      wz_r  <= (w_r == '0);
    end
  end

  // stage 3 and division stages; index i sits in stage 3+i
  logic [AW-1:0]    d_r  [0:SW];
  logic [AW-1:0]    ru_r [0:SW];
  logic [AW-1:0]    rv_r [0:SW];
  logic [SW-1:0]    qu_r [0:SW];
  logic [SW-1:0]    qv_r [0:SW];
  logic [LW-1:0]    lu_r [0:SW];
  logic [LW-1:0]    lv_r [0:SW];
  logic [0:SW]      nx_r, ny_r, ox_r, oy_r, z_r;

  logic [AW-1:0]    ru_nxt [1:SW];
  logic [AW-1:0]    rv_nxt [1:SW];
  logic [SW-1:0]    qu_nxt [1:SW];
  logic [SW-1:0]    qv_nxt [1:SW];

  for (genvar i = 0; i < SW; i++) begin : g_step
    logic [AW:0] tu, tv;
    logic        geu, gev;
    assign tu  = {ru_r[i], lu_r[i][LW-1]};
    assign tv  = {rv_r[i], lv_r[i][LW-1]};
    assign geu = tu >= {1'b0, d_r[i]};
    assign gev = tv >= {1'b0, d_r[i]};
    assign ru_nxt[i+1] = geu ? AW'(tu - {1'b0, d_r[i]}) : tu[AW-1:0];
    assign rv_nxt[i+1] = gev ? AW'(tv - {1'b0, d_r[i]}) : tv[AW-1:0];
    assign qu_nxt[i+1] = {qu_r[i][SW-2:0], geu};
    assign qv_nxt[i+1] = {qv_r[i][SW-2:0], gev};
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      d_r[0]  <= aw_r;
      ru_r[0] <= {{LW{1'b0}}, au_r[AW-1:LW]};
      rv_r[0] <= {{LW{1'b0}}, av_r[AW-1:LW]};
      qu_r[0] <= '0;
      qv_r[0] <= '0;
      lu_r[0] <= au_r[LW-1:0];
      lv_r[0] <= av_r[LW-1:0];
      nx_r[0] <= sgx_r;
      ny_r[0] <= sgy_r;
      ox_r[0] <= {{LW{1'b0}}, au_r[AW-1:LW]} >= aw_r;
      oy_r[0] <= {{LW{1'b0}}, av_r[AW-1:LW]} >= aw_r;
      z_r[0]  <= wz_r;
    end
    for (int i = 1; i <= SW; i++) begin
      if (rdy[3+i]) begin
        d_r[i]  <= d_r[i-1];
        ru_r[i] <= ru_nxt[i];
        rv_r[i] <= rv_nxt[i];
        qu_r[i] <= qu_nxt[i];
        qv_r[i] <= qv_nxt[i];
        lu_r[i] <= {lu_r[i-1][LW-2:0], 1'b0};
        lv_r[i] <= {lv_r[i-1][LW-2:0], 1'b0};
        nx_r[i] <= nx_r[i-1];
        ny_r[i] <= ny_r[i-1];
        ox_r[i] <= ox_r[i-1];
        oy_r[i] <= oy_r[i-1];
        z_r[i]  <= z_r[i-1];
      end
    end
  end

  // output stage: sign, saturation, status
  logic [31:0] xo_nxt, yo_nxt, xo_r, yo_r;
  logic [1:0]  st_nxt, st_r;
  logic        satx, saty;

  always_comb begin
    if (nx_r[SW]) begin
      satx   = ox_r[SW] || (qu_r[SW] > hpt_pkg::SAT_MIN);
      xo_nxt = satx ? hpt_pkg::SAT_MIN : (~qu_r[SW] + 1'b1);
    end else begin
      satx   = ox_r[SW] || qu_r[SW][SW-1];
      xo_nxt = satx ? hpt_pkg::SAT_MAX : qu_r[SW];
    end
    if (ny_r[SW]) begin
      saty   = oy_r[SW] || (qv_r[SW] > hpt_pkg::SAT_MIN);
      yo_nxt = saty ? hpt_pkg::SAT_MIN : (~qv_r[SW] + 1'b1);
    end else begin
      saty   = oy_r[SW] || qv_r[SW][SW-1];
      yo_nxt = saty ? hpt_pkg::SAT_MAX : qv_r[SW];
    end
    st_nxt = (satx || saty) ? hpt_pkg::ST_SAT : hpt_pkg::ST_OK;
    if (z_r[SW]) begin
      xo_nxt = '0;
      yo_nxt = '0;
      st_nxt = hpt_pkg::ST_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      xo_r <= xo_nxt;
      yo_r <= yo_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_tdata = {6'b0, st_r, yo_r, xo_r};

endmodule

`default_nettype wire

@@ hdl/hpt_checker.sv @@
// ----------------------------------------------------------------------------
// hpt_checker
// Port-level checks of the homography point transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [hpt_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [1:0]  st;
  logic [31:0] xo, yo;

  assign st = out_tdata[65:64];
  assign xo = out_tdata[31:0];
  assign yo = out_tdata[63:32];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == hpt_pkg::ST_OK || st == hpt_pkg::ST_SAT ||
                    st == hpt_pkg::ST_ZERO))
    else $error("undefined status code");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == hpt_pkg::ST_ZERO |-> xo == '0 && yo == '0)
    else $error("zero denominator with nonzero outputs");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == hpt_pkg::ST_SAT |->
      (xo == hpt_pkg::SAT_MAX || xo == hpt_pkg::SAT_MIN ||
       yo == hpt_pkg::SAT_MAX || yo == hpt_pkg::SAT_MIN))
    else $error("saturation flagged without a clipped coordinate");

endmodule

bind homography_point_transform_unit hpt_checker u_hpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ bench/homography_point_transform_unit_tb.sv @@
// ----------------------------------------------------------------------------
// homography_point_transform_unit_tb
// Checks the projective point mapper against its own exact-arithmetic
// predictor. Several matrices are loaded between phases: identity, affine,
// mild perspective, fully random, extreme coefficients and a zero bottom row.
// Both stream sides idle at random, except in the closing phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module homography_point_transform_unit_tb;

  localparam logic [hpt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [hpt_pkg::ST_W-1:0]    status;
    logic [hpt_pkg::COORD_W-1:0] y_out;
    logic [hpt_pkg::COORD_W-1:0] x_out;
  } mapped_t;

  class point_scoreboard;
    logic [hpt_pkg::CFG_W-1:0] matrix [5];
    mapped_t pending [$];
    int errors;
    int n_ok, n_sat, n_zero, n_checked;

    function new();
      matrix[hpt_pkg::REG_ROW_ONE]     = hpt_pkg::RST_ROW_ONE;
      matrix[hpt_pkg::REG_ROW_TWO]     = hpt_pkg::RST_ROW_TWO;
      matrix[hpt_pkg::REG_TRANSLATION] = '0;
      matrix[hpt_pkg::REG_PERSPECTIVE] = '0;
      matrix[hpt_pkg::REG_SCALE]       = {32'd0, hpt_pkg::RST_SCALE};
    endfunction

    function void write_reg(logic [hpt_pkg::CFG_IDX_W-1:0] idx,
                            logic [hpt_pkg::CFG_W-1:0] data);
      if (idx == hpt_pkg::REG_SCALE) matrix[idx] = {32'd0, data[31:0]};
      else if (idx <= hpt_pkg::REG_SCALE) matrix[idx] = data;
    endfunction

    function void divide(input logic signed [127:0] num, input logic signed [127:0] den,
                         output logic [hpt_pkg::COORD_W-1:0] q, output logic sat);
      logic neg;
      logic [127:0] n, d, mag;
      neg = num[127] ^ den[127];
      n = num[127] ? -num : num;
      d = den[127] ? -den : den;
      mag = (n << 22) / d;
      sat = 1'b0;
      if (neg) begin
        if (mag > 128'h8000_0000) begin
          q = hpt_pkg::SAT_MIN;
          sat = 1'b1;
        end else begin
          q = -mag[31:0];
        end
      end else begin
        if (mag > 128'h7FFF_FFFF) begin
          q = hpt_pkg::SAT_MAX;
          sat = 1'b1;
        end else begin
          q = mag[31:0];
        end
      end
    endfunction

    function mapped_t map_point(logic [hpt_pkg::COORD_W-1:0] x,
                                logic [hpt_pkg::COORD_W-1:0] y);
      logic signed [127:0] xs, ys, u, v, w;
      logic signed [127:0] h [9];
      logic sx, sy;
      mapped_t r;
      xs = $signed(x);
      ys = $signed(y);
      h[0] = $signed(matrix[hpt_pkg::REG_ROW_ONE][31:0]);
      h[1] = $signed(matrix[hpt_pkg::REG_ROW_ONE][63:32]);
      h[2] = $signed(matrix[hpt_pkg::REG_TRANSLATION][31:0]);
      h[3] = $signed(matrix[hpt_pkg::REG_ROW_TWO][31:0]);
      h[4] = $signed(matrix[hpt_pkg::REG_ROW_TWO][63:32]);
      h[5] = $signed(matrix[hpt_pkg::REG_TRANSLATION][63:32]);
      h[6] = $signed(matrix[hpt_pkg::REG_PERSPECTIVE][31:0]);
      h[7] = $signed(matrix[hpt_pkg::REG_PERSPECTIVE][63:32]);
      h[8] = $signed(matrix[hpt_pkg::REG_SCALE][31:0]);
      u = h[0] * xs + h[1] * ys + (h[2] <<< 24);
      v = h[3] * xs + h[4] * ys + (h[5] <<< 24);
      w = h[6] * xs + h[7] * ys + (h[8] <<< 22);
      r = '0;
      if (w == 0) begin
        r.status = hpt_pkg::ST_ZERO;
      end else begin
        divide(u, w, r.x_out, sx);
        divide(v, w, r.y_out, sy);
        r.status = (sx || sy) ? hpt_pkg::ST_SAT : hpt_pkg::ST_OK;
      end
      return r;
    endfunction

    function void note_point(logic [hpt_pkg::IN_DATA_W-1:0] data);
      pending.push_back(map_point(data[31:0], data[63:32]));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] exp);
      errors++;
      $display("MISMATCH %s: got %h expected %h", what, got, exp);
    endtask

    task check_result(logic [hpt_pkg::OUT_DATA_W-1:0] data);
      mapped_t got, exp;
      got = data[65:0];
      if (pending.size() == 0) begin
        report("unexpected transaction", got.x_out, '0);
      end else begin
        exp = pending.pop_front();
        n_checked++;
        case (exp.status)
          hpt_pkg::ST_OK:  n_ok++;
          hpt_pkg::ST_SAT: n_sat++;
          default:         n_zero++;
        endcase
        if (got.x_out !== exp.x_out) report("x_out", got.x_out, exp.x_out);
        if (got.y_out !== exp.y_out) report("y_out", got.y_out, exp.y_out);
        if (got.status !== exp.status) report("status", got.status, exp.status);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hpt_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [hpt_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [hpt_pkg::OUT_DATA_W-1:0] out_tdata;

  point_scoreboard sb = new();
  bit quiet = 1'b0;
  int idle_cycles = 0;
  int phases_run = 0;

  always #2 clk = ~clk;

  homography_point_transform_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver backpressure in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= rst_n;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_point({y, x});
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_matrix(logic [63:0] r1, logic [63:0] r2, logic [63:0] tr,
                              logic [63:0] pp, logic [31:0] sc);
    logic [hpt_pkg::CFG_W-1:0] vals [5];
    vals = '{r1, r2, tr, pp, {$urandom(), sc}};
    for (int i = 0; i <= 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= (i == 5) ? REG_UNUSED : hpt_pkg::CFG_IDX_W'(i);
      cfg_wdata <= (i == 5) ? {$urandom(), $urandom()} : vals[i];
      @(posedge clk);
      if (i < 5) sb.write_reg(hpt_pkg::CFG_IDX_W'(i), vals[i]);
      else sb.write_reg(REG_UNUSED, '1);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef(int kind, logic [31:0] unit);
    case (kind)
      0: return unit + $urandom_range(0, 65535) - 32768;
      1: return $signed($urandom_range(0, 2 * 2 ** 20)) - 2 ** 20;
      2: return $urandom();
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 2) == 0) return $urandom();
    return $signed($urandom_range(0, 2 ** 25)) - 2 ** 24;
  endfunction

  initial begin
    int kind;
    logic [31:0] edges [4];
    edges = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset matrix is identity: extremes pass through unchanged
    foreach (edges[i]) foreach (edges[j]) send_point(edges[i], edges[j]);
    wait_drained();
    // tiny h8 forces saturation both ways
    write_matrix(hpt_pkg::RST_ROW_ONE, hpt_pkg::RST_ROW_TWO, 64'h0, 64'h0,
                 32'h0000_0001);
    send_point(32'h0001_0000, 32'hFFFF_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h0, 32'h0);
    wait_drained();
    // zero bottom row: every point has a zero denominator
    write_matrix(hpt_pkg::RST_ROW_ONE, hpt_pkg::RST_ROW_TWO, 64'h1234_5678_9ABC_DEF0,
                 64'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0, 32'h0);
    wait_drained();
    // perspective row that cancels h8 at one point
    write_matrix(hpt_pkg::RST_ROW_ONE, hpt_pkg::RST_ROW_TWO, 64'h0,
                 {32'h0, 32'hC000_0000}, 32'h0100_0000);
    send_point(32'h0001_0000, 32'h5);
    send_point(32'h0000_8000, 32'h5);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      kind = (p < 4) ? p : $urandom_range(0, 2);
      if (p == 7) quiet = 1'b1;
      if (p == 6) begin
        write_matrix({32'h0, pick_coef(1, 0)}, {32'h0, pick_coef(1, 0)},
                     {32'h0, pick_coef(2, 0)}, 64'h0, 32'h0);
      end else begin
        write_matrix({pick_coef(kind, 0), pick_coef(kind, 32'h0100_0000)},
                     {pick_coef(kind, 32'h0100_0000), pick_coef(kind, 0)},
                     {pick_coef(kind, 0), pick_coef(kind, 0)},
                     {pick_coef((kind == 0) ? 1 : kind, 0), pick_coef(kind, 0)},
                     pick_coef(kind, 32'h0100_0000));
      end
      for (int n = 0; n < 200; n++) send_point(pick_coord(), pick_coord());
      phases_run++;
    end
    wait_drained();

    $display("Covered %0d results over %0d random matrices plus directed cases:",
             sb.n_checked, phases_run);
    $display("  %0d in range, %0d saturated, %0d zero denominator",
             sb.n_ok, sb.n_sat, sb.n_zero);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
